/* sv/tsrl_pkg.sv */
package tsrl_pkg;

	typedef enum logic [2:0] {
		KIND_TICK      = 3'd0,
		KIND_SAMPLE    = 3'd1,
		KIND_SET_CLOCK = 3'd2,
		KIND_READ      = 3'd3,
		KIND_CLEAR     = 3'd4
	} kind_t;

	// one stored record, also the memory word
	typedef struct packed {
		logic [31:0] stamp;
		logic [7:0]  pct;
		logic [7:0]  phase;
		logic        chg;
		logic        vbus;
		logic [7:0]  wake;
	} rec_t;

	// what travels with an item down the time-of-day pipeline
	typedef struct packed {
		rec_t        rec;
		logic        hit;
		logic        known;
		logic [8:0]  held;
		logic [31:0] dropped;
	} meta_t;

	localparam int REC_W = $bits(rec_t);
	localparam int OFF_W = 34;

	localparam logic [16:0] INTERVAL_RST = 17'd300;
	localparam logic [7:0]  PCT_NONE     = 8'hFF;
	localparam logic [8:0]  PCT_MAX      = 9'd100;

	// multiple of 86400 above 2^32: lifts stamp + offset clear of zero
	localparam logic [OFF_W-1:0] DAY_BIAS = 34'd4295030400;

	// 86400 = 128 * 675; floor(v / 675) = (v * RECIP_675) >> 37 for v < 2^27
	localparam logic [27:0] RECIP_675  = 28'd203613265;
	localparam int          SHIFT_675  = 37;
	localparam logic [9:0]  DIV_675    = 10'd675;
	// floor(s / 3600) = (s * RECIP_3600) >> 27 for s < 86400
	localparam logic [15:0] RECIP_3600 = 16'd37283;
	localparam int          SHIFT_3600 = 27;
	localparam logic [11:0] SECS_HOUR  = 12'd3600;
	// floor(m / 60) = (m * RECIP_60) >> 18 for m < 3600
	localparam logic [12:0] RECIP_60   = 13'd4370;
	localparam int          SHIFT_60   = 18;
	localparam logic [5:0]  SECS_MIN   = 6'd60;

endpackage

/* sv/tsrl_ram.sv */
module tsrl_ram #(
	parameter int WIDTH = 58,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/tsrl_tod.sv */
module tsrl_tod
	import tsrl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  meta_t            in_meta,
	input  logic [OFF_W-1:0] in_off,
	output logic             out_valid,
	input  logic             out_ready,
	output meta_t            out_meta,
	output logic [4:0]       out_hours,
	output logic [5:0]       out_minutes,
	output logic [5:0]       out_seconds
);

	localparam int NSTG = 7;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	meta_t meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7, meta_s8;
	logic [26:0] v_s2, v_s3;
	logic [6:0]  lo_s2, lo_s3;
	logic [17:0] q_s3;
	logic [16:0] secs_s4, secs_s5;
	logic [4:0]  hr_s5, hr_s6, hr_s7, hr_s8;
	logic [11:0] ms_s6, ms_s7;
	logic [5:0]  mn_s7, mn_s8, sc_s8;

	logic [OFF_W-1:0] u;
	logic [54:0]      prod_675;
	logic [26:0]      qm;
	logic [26:0]      rem_675;
	logic [32:0]      prod_hr;
	logic [16:0]      hr_secs;
	logic [16:0]      ms_full;
	logic [24:0]      prod_mn;
	logic [11:0]      mn_secs;
	logic [11:0]      sc_full;
	logic             show;

	// a stage loads when it is empty or its successor moves on
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		u        = {2'b00, in_meta.rec.stamp} + in_off + DAY_BIAS;
		prod_675 = 55'(v_s2) * 55'(RECIP_675);
		qm       = 27'(q_s3) * 27'(DIV_675);
		rem_675  = v_s3 - qm;
		prod_hr  = 33'(secs_s4) * 33'(RECIP_3600);
		hr_secs  = 17'(hr_s5) * 17'(SECS_HOUR);
		ms_full  = secs_s5 - hr_secs;
		prod_mn  = 25'(ms_s6) * 25'(RECIP_60);
		mn_secs  = 12'(mn_s7) * 12'(SECS_MIN);
		sc_full  = ms_s7 - mn_secs;
		show     = meta_s7.hit && meta_s7.known;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			meta_s2 <= in_meta;
			v_s2    <= u[OFF_W-1:7];
			lo_s2   <= u[6:0];
		end
		if (en[1]) begin
			meta_s3 <= meta_s2;
			v_s3    <= v_s2;
			lo_s3   <= lo_s2;
			q_s3    <= prod_675[SHIFT_675 +: 18];
		end
		if (en[2]) begin
			meta_s4 <= meta_s3;
			secs_s4 <= {rem_675[9:0], lo_s3};
		end
		if (en[3]) begin
			meta_s5 <= meta_s4;
			secs_s5 <= secs_s4;
			hr_s5   <= prod_hr[SHIFT_3600 +: 5];
		end
		if (en[4]) begin
			meta_s6 <= meta_s5;
			hr_s6   <= hr_s5;
			ms_s6   <= ms_full[11:0];
		end
		if (en[5]) begin
			meta_s7 <= meta_s6;
			hr_s7   <= hr_s6;
			ms_s7   <= ms_s6;
			mn_s7   <= prod_mn[SHIFT_60 +: 6];
		end
		if (en[6]) begin
			meta_s8 <= meta_s7;
			hr_s8   <= show ? hr_s7 : '0;
			mn_s8   <= show ? mn_s7 : '0;
			sc_s8   <= show ? sc_full[5:0] : '0;
		end
	end

	assign out_valid   = vld_q[NSTG-1];
	assign out_meta    = meta_s8;
	assign out_hours   = hr_s8;
	assign out_minutes = mn_s8;
	assign out_seconds = sc_s8;

endmodule

/* sv/timestamped_status_ring_logger.sv */
// Path: an item passes the read stage (ring update and record memory read) and
// then the seven-stage time-of-day pipeline before its result is valid.
// Throughput: one item per cycle while results are taken; the memory port and
// the seven-stage reciprocal divide pipeline set that figure.
// Reset: asynchronous, empties the ring, forgets the wall clock and loads the
// interval with 300; record memory contents are undefined and not swept.
module timestamped_status_ring_logger
	import tsrl_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [31:0] now_s,
	input  logic [7:0]  phase,
	input  logic signed [8:0] battery_pct,
	input  logic        charging,
	input  logic        vbus_present,
	input  logic [7:0]  wake_cause,
	input  logic signed [31:0] wall_epoch,
	input  logic [7:0]  read_index,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] stamp_s,
	output logic [4:0]  clock_hours,
	output logic [5:0]  clock_minutes,
	output logic [5:0]  clock_seconds,
	output logic        clock_known,
	output logic [7:0]  percent,
	output logic [7:0]  record_phase,
	output logic        record_charging,
	output logic        record_vbus,
	output logic [7:0]  record_wake,
	output logic [8:0]  entries_held,
	output logic [31:0] dropped_total
);

	localparam int AW = $clog2(DEPTH);
	localparam int HW = $clog2(DEPTH + 1);
	// widths for the read index compare and the slot sum
	localparam int CW = (HW > 8) ? HW : 8;
	localparam int SW = ((AW > 8) ? AW : 8) + 1;

	// ring state
	logic [AW-1:0]    wslot_q, wslot_d;
	logic [HW-1:0]    held_q, held_d;
	logic [31:0]      lost_q, lost_d;
	logic [31:0]      last_q, last_d;
	logic [OFF_W-1:0] off_q, off_d;
	logic             known_q, known_d;
	logic [16:0]      interval_q;

	// read stage, lines up with the memory output
	logic             v1_q;
	logic             hit_s1;
	logic             known_s1;
	logic [8:0]       held_s1;
	logic [31:0]      dropped_s1;
	logic [OFF_W-1:0] off_s1;

	logic          accept;
	logic          store;
	logic          hit;
	logic [31:0]   elapsed;
	rec_t          wrec;
	rec_t          rrec;
	logic [AW-1:0] start;
	logic [SW-1:0] slot_sum;
	logic [AW-1:0] raddr;

	meta_t            tod_meta;
	logic             tod_ready;
	meta_t            res_meta;

	assign cfg_ready = 1'b1;

	// the user must change the interval register only between items; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	// accept while the read stage is free or hands its beat on
	assign in_ready = !v1_q || tod_ready;
	assign accept   = in_valid && in_ready;

	// build the record; a reading outside 0..100 is stored as "no reading"
	always_comb begin
		wrec.stamp = now_s;
		wrec.pct   = (battery_pct[8] || (battery_pct > $signed(PCT_MAX))) ?
			PCT_NONE : battery_pct[7:0];
		wrec.phase = phase;
		wrec.chg   = charging;
		wrec.vbus  = vbus_present;
		wrec.wake  = wake_cause;
	end

	// next ring state for the item on the input
	always_comb begin
		wslot_d = wslot_q;
		held_d  = held_q;
		lost_d  = lost_q;
		last_d  = last_q;
		off_d   = off_q;
		known_d = known_q;
		store   = 1'b0;
		elapsed = now_s - last_q;
		case (kind_t'(kind))
			KIND_TICK: begin
				store = (held_q == '0) || (elapsed >= 32'(interval_q));
			end
			KIND_SAMPLE: begin
				store = 1'b1;
			end
			KIND_SET_CLOCK: begin
				// ignore an epoch that is zero or negative
				if (!wall_epoch[31] && (wall_epoch != '0)) begin
					off_d   = {2'b00, wall_epoch} - {2'b00, now_s};
					known_d = 1'b1;
				end
			end
			KIND_CLEAR: begin
				wslot_d = '0;
				held_d  = '0;
				lost_d  = '0;
				last_d  = '0;
				off_d   = '0;
				known_d = 1'b0;
			end
			default: begin
			end
		endcase
		if (store) begin
			wslot_d = (wslot_q == AW'(DEPTH - 1)) ? '0 : wslot_q + 1'b1;
			// overwrite the oldest once full and count the loss
			if (held_q != HW'(DEPTH)) begin
				held_d = held_q + 1'b1;
			end else begin
				lost_d = lost_q + 1'b1;
			end
			last_d = now_s;
		end
	end

	// oldest-first index to memory slot; the oldest sits at the write slot once full
	always_comb begin
		hit      = (kind_t'(kind) == KIND_READ) && (CW'(read_index) < CW'(held_q));
		start    = (held_q == HW'(DEPTH)) ? wslot_q : '0;
		slot_sum = SW'(start) + SW'(read_index);
		if (slot_sum >= SW'(DEPTH)) begin
			slot_sum = slot_sum - SW'(DEPTH);
		end
		raddr = slot_sum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			held_q  <= '0;
			lost_q  <= '0;
			last_q  <= '0;
			off_q   <= '0;
			known_q <= 1'b0;
			v1_q    <= 1'b0;
		end else begin
			if (accept) begin
				wslot_q <= wslot_d;
				held_q  <= held_d;
				lost_q  <= lost_d;
				last_q  <= last_d;
				off_q   <= off_d;
				known_q <= known_d;
			end
			if (in_ready) begin
				v1_q <= in_valid;
			end
		end
	end

	// hold the read stage payload alongside the memory data
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1     <= hit;
			known_s1   <= known_q;
			held_s1    <= 9'(held_d);
			dropped_s1 <= lost_d;
			off_s1     <= off_q;
		end
	end

	tsrl_ram #(
		.WIDTH (REC_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (accept && store),
		.waddr (wslot_q),
		.wdata (wrec),
		.re    (accept),
		.raddr (raddr),
		.rdata (rrec)
	);

	// drop the record fields on anything but a read that lands in the ring
	always_comb begin
		tod_meta.rec     = hit_s1 ? rrec : '0;
		tod_meta.hit     = hit_s1;
		tod_meta.known   = known_s1;
		tod_meta.held    = held_s1;
		tod_meta.dropped = dropped_s1;
	end

	tsrl_tod u_tod (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v1_q),
		.in_ready    (tod_ready),
		.in_meta     (tod_meta),
		.in_off      (off_s1),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_meta    (res_meta),
		.out_hours   (clock_hours),
		.out_minutes (clock_minutes),
		.out_seconds (clock_seconds)
	);

	assign stamp_s         = res_meta.rec.stamp;
	assign clock_known     = res_meta.hit && res_meta.known;
	assign percent         = res_meta.rec.pct;
	assign record_phase    = res_meta.rec.phase;
	assign record_charging = res_meta.rec.chg;
	assign record_vbus     = res_meta.rec.vbus;
	assign record_wake     = res_meta.rec.wake;
	assign entries_held    = res_meta.held;
	assign dropped_total   = res_meta.dropped;

	// the fill count never passes the ring size
	assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(DEPTH))
		else $error("ring fill count beyond depth");

	// a store into a ring that is not full loses nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && store && (held_q != HW'(DEPTH))) |=> (lost_q == $past(lost_q)))
		else $error("dropped count moved while ring not full");

	// a clear empties the ring and forgets the wall clock
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind_t'(kind) == KIND_CLEAR)) |=>
		((held_q == '0) && !known_q && (lost_q == '0)))
		else $error("clear left ring state behind");

	// a result without a known clock shows no time of day
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !clock_known) |->
		((clock_hours == '0) && (clock_minutes == '0) && (clock_seconds == '0)))
		else $error("clock fields set without a known offset");

endmodule
